// ===== hdl/utf8v_pkg.sv =====
// shared types, constants and byte classification functions for the utf-8 validator
package utf8v_pkg;

   // bit masks used to classify a byte
   localparam logic [7:0] MASK_TOP   = 8'h80;
   localparam logic [7:0] MASK_LEAD  = 8'h40;
   localparam logic [7:0] MASK_LEN2  = 8'h20;
   localparam logic [7:0] MASK_LEN3  = 8'h10;
   localparam logic [7:0] MASK_LEN4  = 8'h08;
   localparam logic [7:0] MASK_LEN5  = 8'h04;
   localparam logic [7:0] MASK_LEN6  = 8'h02;

   // continuation counts announced by lead bytes
   localparam logic [2:0] OWED_NONE  = 3'd0;
   localparam logic [2:0] OWED_ONE   = 3'd1;
   localparam logic [2:0] OWED_TWO   = 3'd2;
   localparam logic [2:0] OWED_THREE = 3'd3;
   localparam logic [2:0] OWED_FOUR  = 3'd4;
   localparam logic [2:0] OWED_FIVE  = 3'd5;

   localparam logic [7:0] BYTE_TERM  = 8'h00;

   // per-string scan state
   typedef struct packed {
      logic [2:0] bytes_owed;
      logic       seen_multibyte;
      logic       rejected;
   } scan_state_type;

   localparam scan_state_type SCAN_CLEAR = '{bytes_owed: OWED_NONE,
                                             seen_multibyte: 1'b0,
                                             rejected: 1'b0};

   // printable ascii or one of the allowed control codes
   function automatic logic allowed_ascii(input logic [7:0] b);
      logic ok;
      ok = ((b >= 8'h07) && (b <= 8'h0A)) ||
           (b == 8'h0C) || (b == 8'h0D) || (b == 8'h1B) ||
           ((b >= 8'h20) && (b <= 8'h7E));
      return ok;
   endfunction

   // number of continuation bytes a lead byte announces, zero for 0xfe/0xff
   function automatic logic [2:0] lead_count(input logic [7:0] b);
      logic [2:0] n;
      priority if ((b & MASK_LEN2) == 8'h00) n = OWED_ONE;
      else if ((b & MASK_LEN3) == 8'h00) n = OWED_TWO;
      else if ((b & MASK_LEN4) == 8'h00) n = OWED_THREE;
      else if ((b & MASK_LEN5) == 8'h00) n = OWED_FOUR;
      else if ((b & MASK_LEN6) == 8'h00) n = OWED_FIVE;
      else n = OWED_NONE;
      return n;
   endfunction

endpackage

// ===== hdl/utf8v_decode.sv =====
// per-byte state update and verdict for the utf-8 validator
module utf8v_decode
   import utf8v_pkg::*;
(
   input  logic [7:0]     text_byte,
   input  scan_state_type state_cur,
   output scan_state_type state_nxt,
   output logic           is_term,
   output logic           verdict
);

   logic [2:0] lead_n;

   assign lead_n  = lead_count(text_byte);
   assign is_term = (text_byte == BYTE_TERM);
   assign verdict = !state_cur.rejected && state_cur.seen_multibyte;

   // classify the byte against the current state
   always_comb begin
      state_nxt = state_cur;
      priority if (is_term) begin
         state_nxt = SCAN_CLEAR;
      end else if (state_cur.rejected) begin
         state_nxt = state_cur;
      end else if (state_cur.bytes_owed != OWED_NONE) begin
         // inside a sequence: only 10xxxxxx may follow
         if (((text_byte & MASK_TOP) == 8'h00) || ((text_byte & MASK_LEAD) != 8'h00)) begin
            state_nxt.rejected   = 1'b1;
            state_nxt.bytes_owed = OWED_NONE;
         end else begin
            state_nxt.bytes_owed = state_cur.bytes_owed - 3'd1;
            if (state_cur.bytes_owed == OWED_ONE) begin
               state_nxt.seen_multibyte = 1'b1;
            end
         end
      end else if ((text_byte & MASK_TOP) == 8'h00) begin
         // 7-bit byte outside a sequence
         if (!allowed_ascii(text_byte)) begin
            state_nxt.rejected = 1'b1;
         end
      end else if ((text_byte & MASK_LEAD) == 8'h00) begin
         // stray continuation byte
         state_nxt.rejected = 1'b1;
      end else if (lead_n == OWED_NONE) begin
         state_nxt.rejected = 1'b1;
      end else begin
         state_nxt.bytes_owed = lead_n;
      end
   end

endmodule

// ===== hdl/utf8_text_validator_unit.sv =====
// top level of the utf-8 text validator: input register, byte decode, result register
// a terminator's verdict is computed from the input register and registered for rsp_
// throughput: one byte per cycle unless a terminator waits; the input register is the
//   only stage and the state register is updated in the same cycle the byte leaves it
// a terminator waits in the input register while an earlier verdict is not yet taken
// reset (synchronous, active high) empties both registers and clears the scan state
module utf8_text_validator_unit
   import utf8v_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_is_utf8
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic [7:0]     in_byte_ff;
   scan_state_type state_ff;
   scan_state_type state_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   logic           out_value_ff;

   scan_state_type dec_state;
   logic           dec_term;
   logic           dec_verdict;
   logic           out_free;
   logic           step_fire;

   utf8v_decode u_decode (
      .text_byte (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (dec_state),
      .is_term   (dec_term),
      .verdict   (dec_verdict)
   );

   // held byte moves on unless it is a terminator with the result slot full
   assign out_free  = !out_valid_ff || rsp_ready;
   assign step_fire = in_valid_ff && (!dec_term || out_free);
   assign req_ready = !in_valid_ff || step_fire;

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !step_fire);
   assign state_in     = step_fire ? dec_state : state_ff;
   assign out_valid_in = (step_fire && dec_term) || (out_valid_ff && !rsp_ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= SCAN_CLEAR;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_text_byte;
      end
      if (step_fire && dec_term) begin
         out_value_ff <= dec_verdict;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_is_utf8 = out_value_ff;

endmodule

// ===== hdl/utf8v_checker.sv =====
// port-level checks for the utf-8 text validator and their bind
module utf8v_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_is_utf8
);

   // no verdict is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("verdict offered right after reset");

   // an offered verdict holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_is_utf8)))
      else $error("verdict dropped or changed while stalled");

   // input stalls only behind an untaken verdict
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !req_ready) |-> (rsp_valid && !rsp_ready))
      else $error("input stalled without a waiting verdict");

   // a verdict passes the input and result registers after its terminator; none with empty input history
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid) && !$past(reset)) |-> !$past(reset, 2))
      else $error("verdict appeared too soon after reset");

endmodule

bind utf8_text_validator_unit utf8v_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_is_utf8   (rsp_is_utf8)
);

// ===== bench/utf8v_checker.sv =====
// checker for the utf-8 text validator: byte scan predictor and verdict compare
`timescale 1ns / 100ps

module utf8v_bench_checker
   import utf8v_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic       rsp_is_utf8,
   output int         fail_count,
   output int         pending_count
);

   // predicted scan state of the current string
   logic [2:0] owed_cnt;
   logic       multibyte_done;
   logic       string_bad;

   // verdicts predicted for terminators not yet answered
   logic       verdict_q[$];
   int         mismatches;

   // printable text or an allowed control code
   function automatic logic text_char_ok(input logic [7:0] b);
      return b inside {[8'h07:8'h0A], 8'h0C, 8'h0D, 8'h1B, [8'h20:8'h7E]};
   endfunction

   // continuation bytes announced by a lead byte, none for 0xfe and 0xff
   function automatic logic [2:0] lead_owed(input logic [7:0] b);
      logic [2:0] n;
      casez (b)
         8'b110?????: n = OWED_ONE;
         8'b1110????: n = OWED_TWO;
         8'b11110???: n = OWED_THREE;
         8'b111110??: n = OWED_FOUR;
         8'b1111110?: n = OWED_FIVE;
         default:     n = OWED_NONE;
      endcase
      return n;
   endfunction

   function automatic void clear_scan();
      owed_cnt       = OWED_NONE;
      multibyte_done = 1'b0;
      string_bad     = 1'b0;
   endfunction

   // advance the scan by one accepted byte, queue a verdict on the terminator
   function automatic void scan_text_byte(input logic [7:0] b);
      logic [2:0] n;
      if (b == BYTE_TERM) begin
         verdict_q.push_back(!string_bad && multibyte_done);
         clear_scan();
      end else if (!string_bad) begin
         if (owed_cnt != OWED_NONE) begin
            // inside a sequence only 10xxxxxx may follow
            if (b[7:6] != 2'b10) begin
               string_bad = 1'b1;
               owed_cnt   = OWED_NONE;
            end else begin
               owed_cnt = owed_cnt - 3'd1;
               if (owed_cnt == OWED_NONE)
                  multibyte_done = 1'b1;
            end
         end else if (!b[7]) begin
            if (!text_char_ok(b))
               string_bad = 1'b1;
         end else if (!b[6]) begin
            // stray continuation byte
            string_bad = 1'b1;
         end else begin
            n = lead_owed(b);
            if (n == OWED_NONE)
               string_bad = 1'b1;
            else
               owed_cnt = n;
         end
      end
   endfunction

   function automatic void note_mismatch(input string what, input logic exp_bit,
                                         input logic got_bit);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: expected is_utf8=%0b, got %0b", $realtime, what,
                  exp_bit, got_bit);
   endfunction

   // watch both channels; a transaction on rsp_ takes the oldest prediction
   always @(posedge clock) begin
      logic exp_bit;
      if (reset) begin
         clear_scan();
         verdict_q.delete();
         mismatches = 0;
      end else begin
         if (req_valid && req_ready)
            scan_text_byte(req_text_byte);
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               note_mismatch("verdict with none pending", 1'bx, rsp_is_utf8);
            end else begin
               exp_bit = verdict_q.pop_front();
               if (rsp_is_utf8 !== exp_bit)
                  note_mismatch("verdict mismatch", exp_bit, rsp_is_utf8);
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= verdict_q.size();
   end

endmodule

// ===== bench/tb.sv =====
// testbench top for the utf-8 text validator: clock, reset, byte strings and verdict
`timescale 1ns / 100ps

module tb;
   import utf8v_pkg::*;

   localparam int ITEMS        = 1400;
   localparam int LIMIT        = 400000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_text_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_is_utf8;

   int         fail_count;
   int         pending_count;
   int         cycle_count;
   int         sent;
   bit         quiet;
   int         holds_asked;
   int         holds_served;
   logic [7:0] text_q[$];

   // directed strings: empty, every sequence length, bad leads, stray and bad
   // continuations, unfinished sequence, ignored bytes after rejection, controls
   logic [7:0] directed_q[$] = {
      8'h00,
      8'h07, 8'hC3, 8'hA9, 8'h00,
      8'h0A, 8'hE2, 8'h82, 8'hAC, 8'h00,
      8'h1B, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h00,
      8'hF8, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'h0D, 8'h00,
      8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h00,
      8'hFE, 8'h00,
      8'hFF, 8'h00,
      8'h80, 8'h00,
      8'hC3, 8'h41, 8'h00,
      8'hC3, 8'hC3, 8'h00,
      8'h20, 8'hC3, 8'hA9, 8'hC3, 8'h00,
      8'h7F, 8'hC3, 8'hA9, 8'h00,
      8'h0C, 8'h08, 8'h09, 8'h7E, 8'h00,
      8'h01, 8'h00
   };

   utf8_text_validator_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_utf8   (rsp_is_utf8)
   );

   utf8v_bench_checker u_bench_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_utf8   (rsp_is_utf8),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // idle length: mostly none or short, a few long
   function automatic int gap_len();
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] pick_text_char();
      logic [7:0] ctl[7] = '{8'h07, 8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h1B};
      if ($urandom_range(0, 9) < 7)
         return 8'($urandom_range(8'h20, 8'h7E));
      return ctl[$urandom_range(0, 6)];
   endfunction

   // lead byte announcing n continuation bytes
   function automatic logic [7:0] pick_lead(input int n);
      case (n)
         1:       return 8'($urandom_range(8'hC0, 8'hDF));
         2:       return 8'($urandom_range(8'hE0, 8'hEF));
         3:       return 8'($urandom_range(8'hF0, 8'hF7));
         4:       return 8'($urandom_range(8'hF8, 8'hFB));
         default: return 8'($urandom_range(8'hFC, 8'hFD));
      endcase
   endfunction

   // lead plus continuations; cut drops trailing ones, spoil replaces one
   function automatic void push_sequence(input int n, input int cut, input bit spoil);
      int bad_at;
      bad_at = $urandom_range(0, n - 1);
      text_q.push_back(pick_lead(n));
      for (int i = 0; i < n - cut; i++) begin
         if (spoil && i == bad_at)
            text_q.push_back(8'($urandom_range(1, 255)));
         else
            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      end
   endfunction

   // one random string: mostly well formed, some noise and broken sequences
   function automatic void make_text();
      int segs;
      int n;
      text_q.delete();
      segs = $urandom_range(1, 6);
      if ($urandom_range(0, 3) != 0) begin
         for (int s = 0; s < segs; s++) begin
            if ($urandom_range(0, 2) == 0)
               text_q.push_back(pick_text_char());
            else
               push_sequence($urandom_range(1, 5), 0, 1'b0);
         end
      end else begin
         for (int s = 0; s < segs; s++) begin
            n = $urandom_range(1, 5);
            case ($urandom_range(0, 3))
               0:       text_q.push_back(8'($urandom_range(1, 255)));
               1:       push_sequence(n, $urandom_range(1, n), 1'b0);
               2:       text_q.push_back(pick_text_char());
               default: push_sequence(n, 0, 1'b1);
            endcase
         end
      end
      text_q.push_back(BYTE_TERM);
   endfunction

   // offer one byte after a random gap, return at the accepting edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic send_text();
      foreach (text_q[i])
         send_byte(text_q[i]);
   endtask

   // stop offering and wait until every predicted verdict has arrived
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: random ready, long hold when asked
   initial begin : rx_side
      int run;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (holds_served != holds_asked) begin
            rsp_ready <= 1'b0;
            for (int i = 0; i < HOLD_CYCLES; i++) @(posedge clock);
            holds_served++;
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            run = quiet ? 1 : $urandom_range(1, 8);
            repeat (run) @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat (1 + gap_len()) @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin : tx_side
      bit pressed;
      bit paused;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_text_byte <= BYTE_TERM;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_q[i])
         send_byte(directed_q[i]);

      while (sent < ITEMS) begin
         // hold the result side while short strings keep coming
         if (sent >= 500 && !pressed) begin
            pressed = 1'b1;
            quiet   = 1'b1;
            holds_asked++;
            for (int k = 0; k < 40; k++) begin
               text_q.delete();
               if (k % 2 == 0) begin
                  text_q.push_back(8'hC3);
                  text_q.push_back(8'hA9);
               end else begin
                  text_q.push_back(8'h41);
               end
               text_q.push_back(BYTE_TERM);
               send_text();
            end
            quiet = 1'b0;
         end
         if (sent >= 900 && !paused) begin
            paused = 1'b1;
            wait_drained();
         end
         quiet = (sent >= 1100 && sent < 1250);
         make_text();
         send_text();
      end
      quiet = 1'b0;

      wait_drained();
      if (fail_count == 0 && pending_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== utf8_text_validator_unit.f =====
hdl/utf8v_pkg.sv
hdl/utf8v_decode.sv
hdl/utf8_text_validator_unit.sv
hdl/utf8v_checker.sv
bench/utf8v_checker.sv
bench/tb.sv
